@@ rtl/placement_grid_snap_defines.svh @@
// Assertion macros for the placement grid snap block.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PLACEMENT_GRID_SNAP_DEFINES_SVH
`define PLACEMENT_GRID_SNAP_DEFINES_SVH
`ifndef SYNTHESIS
`define PGS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("placement_grid_snap: check failed");
`define PGS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("placement_grid_snap: check failed");
`else
`define PGS_ASSERT_NOW(lbl, pre, post)
`define PGS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/pgs_pkg.sv @@
// Shared types and constants for the placement grid snap block.
// No dependencies.
package pgs_pkg;

  localparam int ROW_SLOT_W   = 10;
  localparam int ROW_CNT_W    = 11;
  localparam int COLS_W       = 16;
  localparam int SITE_W_W     = 16;
  localparam int PORT_COORD_W = 32;
  localparam int NROW_W       = 10;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_GRID_ORIGIN  = 2'd2,
    CFG_SITE_WIDTH   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_SNAP = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_BELOW,
    ST_RD_HI,
    ST_PICK,
    ST_WAIT_DIV,
    ST_FINAL
  } pgs_state_t;

endpackage

@@ rtl/pgs_row_mem.sv @@
// Row y coordinate table: one write port, one read port with registered data.
// Uses pgs_pkg for nothing beyond house convention.
module pgs_row_mem
  import pgs_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [DW-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0] rd_data
);

  logic signed [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/pgs_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses pgs_pkg for house convention only.
module pgs_div
  import pgs_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     rem_shift;
  logic            ge;

  assign rem_shift = {rem_r, quo_r[NW-1]};
  assign ge        = rem_shift >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(NW);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(rem_shift - {1'b0, dvs_r}) : rem_shift[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

@@ rtl/placement_grid_snap.sv @@
// Placement grid snap: a load command (in_req_type 0) writes a row y into the row table in the
// cycle it is accepted and busy stays low. A snap command raises busy until its result is out;
// the bit-serial site divider and the row search, which probes through the single table read
// port and then picks the nearer row, run alongside, and the result waits for both of them.
// out_valid is a one-cycle strobe that the receiver cannot stall; a new command may be
// issued in that same cycle. Rows must be loaded in ascending order before a snap reads them.
// Depends on pgs_pkg, pgs_row_mem, pgs_div and placement_grid_snap_defines.svh.
`include "placement_grid_snap_defines.svh"
module placement_grid_snap
  import pgs_pkg::*;
#(
  parameter int MAX_ROWS   = 1024,
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [ROW_SLOT_W-1:0]          in_row_slot,
  input  logic signed [PORT_COORD_W-1:0] in_coord_x,
  input  logic signed [PORT_COORD_W-1:0] in_coord_y,
  output logic                           out_valid,
  output logic [NROW_W-1:0]              out_nearest_row,
  output logic [COLS_W-1:0]              out_site_column,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [PORT_COORD_W-1:0]        cfg_wdata
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int CB = COORD_BITS;

  // configuration
  logic [ROW_CNT_W-1:0]    row_count_r;
  logic [COLS_W-1:0]       column_count_r;
  logic [PORT_COORD_W-1:0] origin_r;
  logic [SITE_W_W-1:0]     site_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_CNT_W'(1);
      column_count_r <= COLS_W'(1);
      origin_r       <= '0;
      site_width_r   <= SITE_W_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata[ROW_CNT_W-1:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[COLS_W-1:0];
        CFG_GRID_ORIGIN:  origin_r       <= cfg_wdata;
        CFG_SITE_WIDTH:   site_width_r   <= cfg_wdata[SITE_W_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]       n_eff;
  logic [COLS_W-1:0]   cols_m1;
  logic [SITE_W_W-1:0] sw_eff;

  always_comb begin
    if (row_count_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      n_eff = CW'(MAX_ROWS);
    end else begin
      n_eff = CW'(row_count_r);
    end
  end

  assign cols_m1 = (column_count_r == '0) ? '0 : column_count_r - 1'b1;
  assign sw_eff  = (site_width_r == '0) ? SITE_W_W'(1) : site_width_r;

  // command decode
  pgs_state_t state_r, state_nxt;
  logic       cmd_acc, snap_acc, load_acc;

  assign busy     = (state_r != ST_IDLE);
  assign cmd_acc  = start && !busy;
  assign snap_acc = cmd_acc && (req_type_t'(in_req_type) == REQ_SNAP);
  assign load_acc = cmd_acc && (req_type_t'(in_req_type) == REQ_LOAD);

  logic signed [CB-1:0] x_c, y_c, org_c;
  logic signed [CB:0]   d_full;
  logic                 d_pos;

  assign x_c    = CB'($unsigned(in_coord_x));
  assign y_c    = CB'($unsigned(in_coord_y));
  assign org_c  = CB'(origin_r);
  assign d_full = $signed({x_c[CB-1], x_c}) - $signed({org_c[CB-1], org_c});
  assign d_pos  = !d_full[CB] && (d_full != '0);

  // row table
  logic                 mem_we;
  logic [AW-1:0]        rd_addr;
  logic signed [CB-1:0] rd_data;

  assign mem_we = load_acc && (32'(in_row_slot) < 32'(MAX_ROWS));

  pgs_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (AW),
    .DW    (CB)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_row_slot)),
    .wr_data (y_c),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // site divider
  logic                div_start;
  logic [CB-1:0]       quo;
  logic [SITE_W_W-1:0] rem;
  logic                div_done;

  pgs_div #(
    .NW (CB),
    .DW (SITE_W_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (d_full[CB-1:0]),
    .divisor   (sw_eff),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // search datapath
  logic [CW-1:0]        lo_r, lo_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0]        below_r, below_nxt, nrow_r, nrow_nxt;
  logic signed [CB-1:0] y_r, y_nxt;
  logic                 dpos_r, dpos_nxt;
  logic signed [CB:0]   dlow_r, dlow_nxt, dhigh;
  logic [CW-1:0]        step, probe;
  logic [AW-1:0]        below_c, n_m1;
  logic                 has_pair;
  logic                 round_up;
  logic [CB:0]          q1;
  logic [COLS_W-1:0]    col_c;
  logic                 out_valid_r, out_valid_nxt;
  logic [NROW_W-1:0]    out_row_r, out_row_nxt;
  logic [COLS_W-1:0]    out_col_r, out_col_nxt;

  assign step     = cnt_r >> 1;
  assign probe    = lo_r + step;
  assign below_c  = (lo_r == '0) ? '0 : AW'(lo_r - 1'b1);
  assign has_pair = (CW'(below_c) + 1'b1) < n_eff;
  assign n_m1     = AW'(n_eff - 1'b1);
  assign dhigh    = $signed({rd_data[CB-1], rd_data}) - $signed({y_r[CB-1], y_r});

  // an exact half rounds down
  assign round_up = {rem, 1'b0} > {1'b0, sw_eff};
  assign q1       = {1'b0, quo} + (CB+1)'(round_up);

  always_comb begin
    if (!dpos_r) begin
      col_c = '0;
    end else if (q1 > (CB+1)'(cols_m1)) begin
      col_c = cols_m1;
    end else begin
      col_c = q1[COLS_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (snap_acc) state_nxt = ST_SEARCH;
      ST_SEARCH:   state_nxt = (cnt_r == '0) ? ST_BELOW : ST_CMP;
      ST_CMP:      state_nxt = ST_SEARCH;
      ST_BELOW:    state_nxt = has_pair ? ST_RD_HI : ST_WAIT_DIV;
      ST_RD_HI:    state_nxt = ST_PICK;
      ST_PICK:     state_nxt = ST_WAIT_DIV;
      ST_WAIT_DIV: if (div_done) state_nxt = ST_FINAL;
      ST_FINAL:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    below_nxt     = below_r;
    nrow_nxt      = nrow_r;
    y_nxt         = y_r;
    dpos_nxt      = dpos_r;
    dlow_nxt      = dlow_r;
    rd_addr       = '0;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    case (state_r)
      ST_IDLE: begin
        if (snap_acc) begin
          lo_nxt    = '0;
          cnt_nxt   = n_eff;
          y_nxt     = y_c;
          dpos_nxt  = d_pos;
          div_start = 1'b1;
        end
      end
      ST_SEARCH: rd_addr = probe[AW-1:0];
      ST_CMP: begin
        if (rd_data < y_r) begin
          lo_nxt  = lo_r + step + 1'b1;
          cnt_nxt = cnt_r - step - 1'b1;
        end else begin
          cnt_nxt = step;
        end
      end
      ST_BELOW: begin
        below_nxt = below_c;
        rd_addr   = below_c;
        if (!has_pair) nrow_nxt = n_m1;
      end
      ST_RD_HI: begin
        rd_addr  = below_r + 1'b1;
        dlow_nxt = $signed({y_r[CB-1], y_r}) - $signed({rd_data[CB-1], rd_data});
      end
      ST_PICK: begin
        // tie keeps the lower row
        nrow_nxt = (dlow_r > dhigh) ? below_r + 1'b1 : below_r;
      end
      ST_WAIT_DIV: ;
      ST_FINAL: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = NROW_W'(nrow_r);
        out_col_nxt   = col_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    cnt_r     <= cnt_nxt;
    below_r   <= below_nxt;
    nrow_r    <= nrow_nxt;
    y_r       <= y_nxt;
    dpos_r    <= dpos_nxt;
    dlow_r    <= dlow_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_nearest_row = out_row_r;
  assign out_site_column = out_col_r;

  `PGS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `PGS_ASSERT_NOW(a_col_in_range, out_valid, out_site_column <= cols_m1)
  `PGS_ASSERT_NOW(a_row_in_range, out_valid, CW'(nrow_r) < n_eff)
  `PGS_ASSERT_NEXT(a_snap_busy, snap_acc, busy)
  `PGS_ASSERT_NEXT(a_probe_cmp, state_r == ST_SEARCH && cnt_r != '0, state_r == ST_CMP)

endmodule

@@ sim/tb.sv @@
// Self-checking bench for placement_grid_snap: row table loads and point snaps.
// Each accepted snap is predicted from a local copy of the row table and grid registers.
// Depends on pgs_pkg and the placement_grid_snap RTL.
`timescale 1ns / 1ps

module tb
  import pgs_pkg::*;
();

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [NROW_W-1:0] nearest_row;
    logic [COLS_W-1:0] site_column;
  } snap_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_req_type = REQ_LOAD;
  logic [ROW_SLOT_W-1:0]          in_row_slot = '0;
  logic signed [PORT_COORD_W-1:0] in_coord_x = '0;
  logic signed [PORT_COORD_W-1:0] in_coord_y = '0;
  logic                           out_valid;
  logic [NROW_W-1:0]              out_nearest_row;
  logic [COLS_W-1:0]              out_site_column;
  logic                           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = CFG_ROW_COUNT;
  logic [PORT_COORD_W-1:0]        cfg_wdata = '0;

  placement_grid_snap uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_row_slot     (in_row_slot),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_nearest_row (out_nearest_row),
    .out_site_column (out_site_column),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // local copy of the grid registers and the row table
  logic [ROW_CNT_W-1:0]   row_count_cfg = ROW_CNT_W'(1);
  logic [COLS_W-1:0]      column_count_cfg = COLS_W'(1);
  logic signed [31:0]     origin_cfg = 0;
  logic [SITE_W_W-1:0]    site_width_cfg = SITE_W_W'(1);
  logic signed [31:0]     row_y_shadow [TABLE_DEPTH];

  snap_result_t pending_snaps [$];
  snap_result_t oldest;
  int error_count = 0;
  int idle_pct = 0;

  function automatic longint rows_in_use();
    longint n;
    n = longint'(row_count_cfg);
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic logic [NROW_W-1:0] nearest_row_of(longint y);
    longint n, lo, count, step, below, d_low, d_high, pick;
    n = rows_in_use();
    lo = 0;
    count = n;
    // lower-bound search: first row at or above y
    while (count > 0) begin
      step = count / 2;
      if (longint'(row_y_shadow[lo + step]) < y) begin
        lo = lo + step + 1;
        count = count - step - 1;
      end else begin
        count = step;
      end
    end
    below = (lo == 0) ? 0 : lo - 1;
    if (below + 1 < n) begin
      d_low  = y - longint'(row_y_shadow[below]);
      d_high = longint'(row_y_shadow[below + 1]) - y;
      pick = (d_low > d_high) ? below + 1 : below;
    end else begin
      pick = n - 1;
    end
    return pick[NROW_W-1:0];
  endfunction

  function automatic logic [COLS_W-1:0] site_column_of(longint x);
    longint cols, sw, d, q, r;
    cols = (column_count_cfg == 0) ? 1 : longint'(column_count_cfg);
    sw = (site_width_cfg == 0) ? 1 : longint'(site_width_cfg);
    d = x - longint'(origin_cfg);
    if (d <= 0) return '0;
    q = d / sw;
    r = d % sw;
    if (2 * r > sw) q = q + 1;  // exact half stays down
    if (q > cols - 1) q = cols - 1;
    return q[COLS_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] random_extreme();
    return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
  endfunction

  function automatic logic signed [31:0] pick_snap_y();
    longint n, r, v;
    int off;
    n = rows_in_use();
    r = $urandom_range(0, n - 1);
    off = $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4: begin
        // midpoints give exact ties when the row sum is even
        if (r + 1 < n)
          v = (longint'(row_y_shadow[r]) + longint'(row_y_shadow[r + 1])) / 2;
        else
          v = longint'(row_y_shadow[r]);
      end
      5, 6, 7, 8: v = longint'(row_y_shadow[r]) + off - 4;
      default: return random_extreme();
    endcase
    return sat32(v);
  endfunction

  function automatic logic signed [31:0] pick_snap_x();
    longint sw, cols, k, v;
    int off;
    sw = (site_width_cfg == 0) ? 1 : longint'(site_width_cfg);
    cols = (column_count_cfg == 0) ? 1 : longint'(column_count_cfg);
    k = $urandom_range(0, cols + 1);
    off = $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: v = longint'(origin_cfg) + k * sw + sw / 2;
      3: v = longint'(origin_cfg) + k * sw + (sw + 1) / 2;
      4, 5, 6: v = longint'(origin_cfg) + k * sw + off - 2;
      7: v = longint'(origin_cfg) - longint'($urandom_range(0, 1000));
      default: return random_extreme();
    endcase
    return sat32(v);
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (error_count < 200)
      $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_snaps.size() == 0) begin
        report_mismatch("result with no snap pending, row", -1, out_nearest_row);
      end else begin
        oldest = pending_snaps.pop_front();
        if (out_nearest_row !== oldest.nearest_row)
          report_mismatch("nearest_row", oldest.nearest_row, out_nearest_row);
        if (out_site_column !== oldest.site_column)
          report_mismatch("site_column", oldest.site_column, out_site_column);
      end
    end
  end

  // called at a rising edge; returns at the edge of the transfer with start still high
  task automatic send_item(input req_type_t kind, input logic [ROW_SLOT_W-1:0] slot,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    snap_result_t want;
    in_req_type <= kind;
    in_row_slot <= slot;
    in_coord_x  <= x;
    in_coord_y  <= y;
    start       <= 1'b1;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    if (kind == REQ_LOAD) begin
      row_y_shadow[slot] = y;
    end else begin
      want.nearest_row = nearest_row_of(longint'(y));
      want.site_column = site_column_of(longint'(x));
      pending_snaps.push_back(want);
    end
  endtask

  task automatic pause_after_item();
    int n;
    n = 0;
    while (n < 60 && $urandom_range(99) < idle_pct) n++;
    // now and then a long gap so the next start lands late in a snap
    if (idle_pct != 0 && $urandom_range(0, 11) == 0) n = $urandom_range(0, 45);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROW_COUNT:    row_count_cfg = value[ROW_CNT_W-1:0];
      CFG_COLUMN_COUNT: column_count_cfg = value[COLS_W-1:0];
      CFG_GRID_ORIGIN:  origin_cfg = value;
      CFG_SITE_WIDTH:   site_width_cfg = value[SITE_W_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_ascending_rows(input int n, input int max_step);
    longint span, y;
    int i;
    span = 64'd4294967295 - longint'(n) * longint'(max_step);
    y = longint'(COORD_MIN) + (longint'($urandom) % (span + 1));
    for (i = 0; i < n; i++) begin
      send_item(REQ_LOAD, i[ROW_SLOT_W-1:0], $urandom, y[31:0]);
      pause_after_item();
      y = y + longint'($urandom_range(0, max_step));
    end
  endtask

  task automatic load_unsorted_rows(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_item(REQ_LOAD, i[ROW_SLOT_W-1:0], $urandom, $urandom);
      pause_after_item();
    end
  endtask

  task automatic send_random_snaps(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_item(REQ_SNAP, ROW_SLOT_W'($urandom), pick_snap_x(), pick_snap_y());
      pause_after_item();
    end
  endtask

  task automatic test_reset_defaults();
    send_item(REQ_LOAD, '0, $urandom, $urandom);
    send_random_snaps(2);
  endtask

  task automatic test_directed_cases();
    drain_results();
    write_reg(CFG_ROW_COUNT, 4);
    write_reg(CFG_COLUMN_COUNT, 100);
    write_reg(CFG_GRID_ORIGIN, 0);
    write_reg(CFG_SITE_WIDTH, 10);
    send_item(REQ_LOAD, 10'd1023, COORD_MAX, COORD_MIN);
    send_item(REQ_LOAD, 10'd0, 32'sd0, -32'sd1000);
    send_item(REQ_LOAD, 10'd1, 32'sd0, 32'sd0);
    send_item(REQ_LOAD, 10'd2, 32'sd0, 32'sd100);
    send_item(REQ_LOAD, 10'd3, 32'sd0, COORD_MAX - 1);
    send_item(REQ_SNAP, 10'd0, 32'sd15, 32'sd50);         // row tie and column half
    send_item(REQ_SNAP, 10'd1023, 32'sd25, 32'sd51);
    send_item(REQ_SNAP, 10'd5, 32'sd16, COORD_MIN);        // below every row
    send_item(REQ_SNAP, 10'd0, -32'sd5, COORD_MAX);        // above every row, left of origin
    send_item(REQ_SNAP, 10'd0, COORD_MAX, 32'sd100);       // column clamps high
    send_item(REQ_SNAP, 10'd0, COORD_MIN, 32'sd0);
    send_item(REQ_SNAP, 10'd0, 32'sd0, -32'sd1000);
    send_item(REQ_SNAP, 10'd0, 32'sd1, -32'sd501);
    drain_results();
    write_reg(CFG_COLUMN_COUNT, 0);
    write_reg(CFG_SITE_WIDTH, 0);
    send_item(REQ_SNAP, 10'd0, 32'sd12345, COORD_MAX);
    drain_results();
    write_reg(CFG_COLUMN_COUNT, 65535);
    send_item(REQ_SNAP, 10'd0, 32'sd40000, 32'sd40);
    drain_results();
    write_reg(CFG_GRID_ORIGIN, COORD_MIN);
    write_reg(CFG_SITE_WIDTH, 65535);
    send_item(REQ_SNAP, 10'd0, COORD_MAX, 32'sd0);
    drain_results();
    write_reg(CFG_GRID_ORIGIN, COORD_MAX);
    send_item(REQ_SNAP, 10'd0, COORD_MIN, 32'sd0);
    send_item(REQ_SNAP, 10'd0, COORD_MAX, 32'sd0);
    drain_results();
    write_reg(CFG_ROW_COUNT, 0);
    send_item(REQ_SNAP, 10'd0, 32'sd5, 32'sd5);
  endtask

  task automatic test_full_row_table();
    drain_results();
    idle_pct = 0;
    write_reg(CFG_ROW_COUNT, TABLE_DEPTH);
    write_reg(CFG_COLUMN_COUNT, 65535);
    write_reg(CFG_GRID_ORIGIN, $urandom);
    write_reg(CFG_SITE_WIDTH, $urandom_range(1, 64));
    load_ascending_rows(TABLE_DEPTH, 1 << 21);
    idle_pct = 21;
    send_random_snaps(30);
    drain_results();
    write_reg(CFG_ROW_COUNT, 2047);  // above the table depth
    send_random_snaps(6);
    drain_results();
    write_reg(CFG_ROW_COUNT, 0);
    send_random_snaps(3);
  endtask

  task automatic test_random_grids();
    int phase, i, n, rc;
    for (phase = 0; phase < 14; phase++) begin
      drain_results();
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 80 : 21;
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = 2;
        default: n = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 15))
        0: rc = 0;
        1: rc = 2047;
        2, 3: rc = n + $urandom_range(1, 20);
        default: rc = n;
      endcase
      write_reg(CFG_ROW_COUNT, rc);
      case ($urandom_range(0, 11))
        0: write_reg(CFG_COLUMN_COUNT, 0);
        1: write_reg(CFG_COLUMN_COUNT, 65535);
        2: write_reg(CFG_COLUMN_COUNT, 1);
        default: write_reg(CFG_COLUMN_COUNT, $urandom_range(2, 300));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(CFG_GRID_ORIGIN, COORD_MIN);
        1: write_reg(CFG_GRID_ORIGIN, COORD_MAX);
        2, 3, 4, 5: write_reg(CFG_GRID_ORIGIN, $urandom_range(0, 2000) - 1000);
        default: write_reg(CFG_GRID_ORIGIN, $urandom);
      endcase
      case ($urandom_range(0, 11))
        0: write_reg(CFG_SITE_WIDTH, 0);
        1: write_reg(CFG_SITE_WIDTH, 65535);
        default: write_reg(CFG_SITE_WIDTH, $urandom_range(1, 100));
      endcase
      if (phase % 6 == 5)
        load_unsorted_rows(n);
      else
        case ($urandom_range(0, 2))
          0: load_ascending_rows(n, 4);
          1: load_ascending_rows(n, 1000);
          default: load_ascending_rows(n, 1 << 21);
        endcase
      for (i = 0; i < 22; i++) begin
        // hold off until every snap in flight has returned
        if (i == 11 && (phase == 1 || $urandom_range(0, 3) == 0)) drain_results();
        if ($urandom_range(0, 19) == 0)
          send_item(REQ_LOAD, ROW_SLOT_W'($urandom_range(0, n - 1)), $urandom, $urandom);
        else
          send_item(REQ_SNAP, ROW_SLOT_W'($urandom), pick_snap_x(), pick_snap_y());
        pause_after_item();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_full_row_table();
    test_random_grids();
    drain_results();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pgs_pkg.sv
rtl/pgs_row_mem.sv
rtl/pgs_div.sv
rtl/placement_grid_snap.sv
sim/tb.sv
